[design/biquad_bandpass_filter_macros.svh]
// Assertion macros used by the band-pass filter top level.
`ifndef BIQUAD_BANDPASS_FILTER_MACROS_SVH
`define BIQUAD_BANDPASS_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BQBP_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("bqbp same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BQBP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("bqbp next-cycle check failed");

`endif

[design/bqbp_pkg.sv]
// Package with widths, register indexes and coefficient reset values of the band-pass filter.
`default_nettype none

package bqbp_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COEF_BITS_DEF   = 24;
  localparam int STATE_BITS_DEF  = 32;

  // Reset coefficients are given in Q2.22 at 24 bits.
  localparam int COEF_REF_BITS = 24;
  localparam longint GAIN_RESET_REF = 64'sd52056;
  localparam longint FB_ONE_RESET_REF = -64'sd8219820;
  localparam longint FB_TWO_RESET_REF = 64'sd4090193;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_ONE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_TWO = 2'd2;

  localparam int OUT_BITS = 16;
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = 16'sh8000;

  // Moves a 24-bit reference coefficient to another coefficient width.
  function automatic longint scale_coef(input longint value, input int bits);
    longint result;
    if (bits >= COEF_REF_BITS) begin
      result = value <<< (bits - COEF_REF_BITS);
    end else begin
      result = value >>> (COEF_REF_BITS - bits);
    end
    return result;
  endfunction

endpackage

`default_nettype wire

[design/biquad_bandpass_filter.sv]
// Top level of the second-order IIR band-pass filter with input gain.
//
//   Channel   Direction  Handshake                   Payload
//   sample    in         sample_valid/sample_stall   sample, frame_start
//   result    out        result_valid/result_stall   filtered, clipped
//   config    in         cfg_write                   cfg_index, cfg_data
//
// One sample per cycle is sustained unless the result is stalled. The whole
// recursion (three multiplies, sum, saturation) runs combinationally from the
// input register into the result register, so a result is registered as its
// sample leaves the input register. Reset restores the coefficient defaults,
// clears both delays and empties the pipeline. The sample side is stalled
// only while the input register is full and the result is stalled.
`default_nettype none

`include "biquad_bandpass_filter_macros.svh"

module biquad_bandpass_filter #(
  parameter int SAMPLE_BITS = bqbp_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqbp_pkg::COEF_BITS_DEF,
  parameter int STATE_BITS  = bqbp_pkg::STATE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   sample_valid,
  output logic                                        sample_stall,
  input  wire logic [SAMPLE_BITS-1:0]                 sample,
  input  wire logic                                   frame_start,
  output logic                                        result_valid,
  input  wire logic                                   result_stall,
  output logic signed [bqbp_pkg::OUT_BITS-1:0]        filtered,
  output logic                                        clipped,
  input  wire logic                                   cfg_write,
  input  wire logic [bqbp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [COEF_BITS-1:0]                   cfg_data
);

  import bqbp_pkg::*;

  localparam int STATE_FRAC = STATE_BITS - 16;
  localparam int COEF_FRAC  = COEF_BITS - 2;
  localparam int XS_W       = SAMPLE_BITS + STATE_FRAC + 1;
  localparam int GT_W       = XS_W + 2;
  localparam int FT_W       = STATE_BITS + 2;
  localparam int SUM_W      = ((GT_W > FT_W) ? GT_W : FT_W) + 2;
  localparam int Y_W        = STATE_BITS + 1;
  localparam int WHOLE_W    = Y_W - STATE_FRAC;

  localparam logic signed [COEF_BITS-1:0] GAIN_RESET =
    COEF_BITS'(scale_coef(GAIN_RESET_REF, COEF_BITS));
  localparam logic signed [COEF_BITS-1:0] FB_ONE_RESET =
    COEF_BITS'(scale_coef(FB_ONE_RESET_REF, COEF_BITS));
  localparam logic signed [COEF_BITS-1:0] FB_TWO_RESET =
    COEF_BITS'(scale_coef(FB_TWO_RESET_REF, COEF_BITS));

  localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

  // Coefficient registers.
  logic signed [COEF_BITS-1:0] input_gain;
  logic signed [COEF_BITS-1:0] feedback_one;
  logic signed [COEF_BITS-1:0] feedback_two;

  // Filter state.
  logic signed [STATE_BITS-1:0] delay_one;
  logic signed [STATE_BITS-1:0] delay_two;

  // Input register.
  logic                   in_full;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_frame;

  logic out_ready;
  logic advance;

  assign out_ready    = !result_valid || !result_stall;
  assign advance      = in_full && out_ready;
  assign sample_stall = in_full && !out_ready;

  // Recursion datapath.
  logic signed [STATE_BITS-1:0]        d1_eff;
  logic signed [STATE_BITS-1:0]        d2_eff;
  logic signed [XS_W-1:0]              xs;
  logic signed [XS_W+COEF_BITS-1:0]    prod_gain;
  logic signed [XS_W+COEF_BITS-1:0]    shift_gain;
  logic signed [STATE_BITS+COEF_BITS-1:0] prod_one;
  logic signed [STATE_BITS+COEF_BITS-1:0] prod_two;
  logic signed [STATE_BITS+COEF_BITS-1:0] shift_one;
  logic signed [STATE_BITS+COEF_BITS-1:0] shift_two;
  logic signed [GT_W-1:0]              term_gain;
  logic signed [FT_W-1:0]              term_one;
  logic signed [FT_W-1:0]              term_two;
  logic signed [SUM_W-1:0]             w_sum;
  logic signed [STATE_BITS-1:0]        w_next;
  logic signed [Y_W-1:0]               y;
  logic signed [Y_W-1:0]               y_round;
  logic signed [Y_W-1:0]               y_shift;
  logic signed [WHOLE_W-1:0]           whole;
  logic signed [OUT_BITS-1:0]          filtered_next;
  logic                                clipped_next;

  always_comb begin
    d1_eff = in_frame ? '0 : delay_one;
    d2_eff = in_frame ? '0 : delay_two;
    xs     = signed'({1'b0, in_sample, {STATE_FRAC{1'b0}}});

    prod_gain = xs * input_gain;
    prod_one  = d1_eff * feedback_one;
    prod_two  = d2_eff * feedback_two;

    // Arithmetic shifts drop the fraction bits, which rounds toward minus infinity.
    shift_gain = prod_gain >>> COEF_FRAC;
    shift_one  = prod_one >>> COEF_FRAC;
    shift_two  = prod_two >>> COEF_FRAC;
    term_gain  = signed'(shift_gain[GT_W-1:0]);
    term_one   = signed'(shift_one[FT_W-1:0]);
    term_two   = signed'(shift_two[FT_W-1:0]);

    w_sum = SUM_W'(term_gain) - SUM_W'(term_one) - SUM_W'(term_two);

    // The sum fits the state width when all bits above its sign agree.
    if (w_sum[SUM_W-1:STATE_BITS-1] == '0 || w_sum[SUM_W-1:STATE_BITS-1] == '1) begin
      w_next = signed'(w_sum[STATE_BITS-1:0]);
    end else if (w_sum[SUM_W-1]) begin
      w_next = STATE_MIN;
    end else begin
      w_next = STATE_MAX;
    end

    y = Y_W'(w_next) - Y_W'(d2_eff);
    // Bias negative values so the shift truncates toward zero.
    y_round = y[Y_W-1] ? signed'(Y_W'({STATE_FRAC{1'b1}})) : '0;
    y_shift = (y + y_round) >>> STATE_FRAC;
    whole   = signed'(y_shift[WHOLE_W-1:0]);

    if (whole[WHOLE_W-1] != whole[OUT_BITS-1]) begin
      clipped_next  = 1'b1;
      filtered_next = whole[WHOLE_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      clipped_next  = 1'b0;
      filtered_next = signed'(whole[OUT_BITS-1:0]);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain   <= GAIN_RESET;
      feedback_one <= FB_ONE_RESET;
      feedback_two <= FB_TWO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INPUT_GAIN:   input_gain   <= signed'(cfg_data);
        REG_FEEDBACK_ONE: feedback_one <= signed'(cfg_data);
        REG_FEEDBACK_TWO: feedback_two <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Control and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
      delay_one    <= '0;
      delay_two    <= '0;
    end else begin
      if (!sample_stall) begin
        in_full <= sample_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
        delay_one    <= w_next;
        delay_two    <= d1_eff;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_sample <= sample;
      in_frame  <= frame_start;
    end
    if (advance) begin
      filtered <= filtered_next;
      clipped  <= clipped_next;
    end
  end

  `BQBP_ASSERT_NOW(a_stall_needs_item, clk, rst, sample_stall, in_full && result_valid)
  `BQBP_ASSERT_NEXT(a_advance_gives_result, clk, rst, advance, result_valid)
  `BQBP_ASSERT_NEXT(a_frame_clears_delay, clk, rst, advance && in_frame, delay_two == '0)
  `BQBP_ASSERT_NOW(a_clip_at_rail, clk, rst, result_valid && clipped,
                   filtered == OUT_MAX || filtered == OUT_MIN)

endmodule

`default_nettype wire
